@@ sv/mtg_pkg.sv @@
`timescale 1ns / 1ps

package mtg_pkg;

	// table geometry
	localparam int TABLE_WORDS  = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int IDX_W        = 10;

	// index of the last table word and the wrap point of the far read
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_WORDS - 1);
	localparam logic [IDX_W-1:0] FAR_WRAP  = IDX_W'(TABLE_WORDS - TWIST_OFFSET);
	localparam logic [IDX_W-1:0] FAR_STEP  = IDX_W'(TWIST_OFFSET);

	// seeding LCG: one word takes two steps, folded into a single jump
	localparam logic [31:0] LCG_MUL      = 32'd69069;
	localparam logic [31:0] LCG_MUL2     = 32'(64'(69069) * 64'(69069));
	localparam logic [31:0] LCG_ADD2     = 32'd69070;
	localparam logic [31:0] DEFAULT_SEED = 32'd4357;

	localparam logic [31:0] TWIST_MATRIX = 32'h9908B0DF;
	localparam logic [31:0] TEMPER_B     = 32'h9D2C5680;
	localparam logic [31:0] TEMPER_C     = 32'hEFC60000;
	localparam logic [31:0] HIGH_HALF    = 32'hFFFF0000;

	localparam logic OP_DRAW = 1'b0;
	localparam logic OP_SEED = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_ISSUE,
		ST_DRAW
	} mtg_state_t;

	// controller to datapath
	typedef struct packed {
		logic fill_start;
		logic fill_default;
		logic fill_step;
		logic draw_issue;
		logic draw_commit;
	} mtg_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic fill_last;
		logic need_reseed;
		logic out_busy;
	} mtg_sts_t;

	function automatic logic [31:0] temper(input logic [31:0] v);
		logic [31:0] t;
		t = v ^ (v >> 11);
		t = t ^ ((t << 7) & TEMPER_B);
		t = t ^ ((t << 15) & TEMPER_C);
		t = t ^ (t >> 18);
		return t;
	endfunction

endpackage

@@ sv/mtg_ctrl.sv @@
`timescale 1ns / 1ps

module mtg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              opcode,
	output logic              in_stall,
	input  mtg_pkg::mtg_sts_t sts,
	output mtg_pkg::mtg_cmd_t cmd
);

	mtg_pkg::mtg_state_t state_q, state_d;
	logic                pend_q, pend_d;

	// hold state and the pending-draw flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mtg_pkg::ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		pend_d   = pend_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			mtg_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (opcode == mtg_pkg::OP_SEED) begin
						cmd.fill_start = 1'b1;
						pend_d         = 1'b0;
						state_d        = mtg_pkg::ST_FILL;
					end else if (sts.need_reseed) begin
						cmd.fill_start   = 1'b1;
						cmd.fill_default = 1'b1;
						pend_d           = 1'b1;
						state_d          = mtg_pkg::ST_FILL;
					end else begin
						cmd.draw_issue = 1'b1;
						state_d        = mtg_pkg::ST_DRAW;
					end
				end
			end
			mtg_pkg::ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) begin
					state_d = pend_q ? mtg_pkg::ST_ISSUE : mtg_pkg::ST_IDLE;
					pend_d  = 1'b0;
				end
			end
			mtg_pkg::ST_ISSUE: begin
				cmd.draw_issue = 1'b1;
				state_d        = mtg_pkg::ST_DRAW;
			end
			mtg_pkg::ST_DRAW: begin
				if (!sts.out_busy) begin
					cmd.draw_commit = 1'b1;
					state_d         = mtg_pkg::ST_IDLE;
				end
			end
			default: state_d = mtg_pkg::ST_IDLE;
		endcase
	end

	// a draw that forced a reseed goes on to read once the fill ends
	a_pend_to_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mtg_pkg::ST_FILL && sts.fill_last && pend_q)
		|=> (state_q == mtg_pkg::ST_ISSUE))
		else $error("pending draw lost after reseed fill");

	// reads are issued only from idle or the issue state
	a_issue_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_issue |-> (state_q == mtg_pkg::ST_IDLE || state_q == mtg_pkg::ST_ISSUE))
		else $error("read issued from wrong state");

endmodule

@@ sv/mtg_dp.sv @@
`timescale 1ns / 1ps

module mtg_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [31:0]       seed_value,
	input  mtg_pkg::mtg_cmd_t cmd,
	output mtg_pkg::mtg_sts_t sts,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [31:0]       random_word
);

	logic [31:0]                 mem [mtg_pkg::TABLE_WORDS];
	logic [mtg_pkg::IDX_W-1:0]   idx_q;
	logic [mtg_pkg::IDX_W-1:0]   fill_idx_q;
	logic [31:0]                 cache_q;
	logic [31:0]                 lcg_q;
	logic [31:0]                 rd_nxt_q;
	logic [31:0]                 rd_far_q;
	logic                        out_valid_q;
	logic [31:0]                 out_word_q;

	logic [mtg_pkg::IDX_W-1:0]   nxt_idx;
	logic [mtg_pkg::IDX_W-1:0]   far_idx;
	logic [31:0]                 lcg_one;
	logic [31:0]                 fill_word;
	logic [31:0]                 y;
	logic [31:0]                 mix;
	logic [31:0]                 new_word;
	logic                        wr_en;
	logic [mtg_pkg::IDX_W-1:0]   wr_addr;
	logic [31:0]                 wr_data;

	// neighbour and far addresses of the current word
	assign nxt_idx = (idx_q == mtg_pkg::LAST_IDX) ? '0 : idx_q + 1'b1;
	assign far_idx = (idx_q >= mtg_pkg::FAR_WRAP) ? idx_q - mtg_pkg::FAR_WRAP
	                                              : idx_q + mtg_pkg::FAR_STEP;

	// seeding word: high half of the LCG, then high half after one step
	assign lcg_one   = lcg_q * mtg_pkg::LCG_MUL + 32'd1;
	assign fill_word = (lcg_q & mtg_pkg::HIGH_HALF) | {16'd0, lcg_one[31:16]};

	// twist the current word on the fly
	assign y        = {cache_q[31], rd_nxt_q[30:0]};
	assign mix      = {1'b0, y[31:1]} ^ (y[0] ? mtg_pkg::TWIST_MATRIX : 32'd0);
	assign new_word = rd_far_q ^ mix;

	// single write port shared by fill and draw
	assign wr_en   = cmd.fill_step | cmd.draw_commit;
	assign wr_addr = cmd.fill_step ? fill_idx_q : idx_q;
	assign wr_data = cmd.fill_step ? fill_word : new_word;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered reads of the neighbour and far words
	always_ff @(posedge clk) begin
		if (cmd.draw_issue) begin
			rd_nxt_q <= mem[nxt_idx];
			rd_far_q <= mem[far_idx];
		end
	end

	// advance the seeding LCG two steps per word
	always_ff @(posedge clk) begin
		if (cmd.fill_start) begin
			lcg_q <= cmd.fill_default ? mtg_pkg::DEFAULT_SEED : seed_value;
		end else if (cmd.fill_step) begin
			lcg_q <= lcg_q * mtg_pkg::LCG_MUL2 + mtg_pkg::LCG_ADD2;
		end
	end

	// hold the read index, the fill index and the current word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			fill_idx_q <= '0;
			cache_q    <= '0;
		end else begin
			if (cmd.fill_start) begin
				idx_q      <= '0;
				fill_idx_q <= '0;
			end else if (cmd.fill_step) begin
				fill_idx_q <= (fill_idx_q == mtg_pkg::LAST_IDX) ? '0 : fill_idx_q + 1'b1;
				if (fill_idx_q == '0) begin
					cache_q <= fill_word;
				end
			end else if (cmd.draw_commit) begin
				idx_q   <= nxt_idx;
				cache_q <= rd_nxt_q;
			end
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.draw_commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw_commit) begin
			out_word_q <= mtg_pkg::temper(new_word);
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = out_word_q;

	assign sts.fill_last   = (fill_idx_q == mtg_pkg::LAST_IDX);
	assign sts.need_reseed = (idx_q == '0) && (cache_q == 32'd0);
	assign sts.out_busy    = out_valid_q & out_stall;

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q <= mtg_pkg::LAST_IDX) && (fill_idx_q <= mtg_pkg::LAST_IDX))
		else $error("table index out of range");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.draw_commit |-> !sts.out_busy)
		else $error("draw committed over a waiting word");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.draw_commit))
		else $error("output word without a draw");

	a_one_write: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.fill_step && cmd.draw_commit))
		else $error("fill and draw write together");

endmodule

@@ sv/mersenne_twister_generator.sv @@
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// in       in_valid / in_stall  opcode, seed_value
// out      out_valid / out_stall random_word
//
// A draw reads the neighbour and far words from the two-read-port table,
// then twists, writes back and tempers.
// A seed request makes one LCG jump per table word, 624 writes.
// A draw at word 0 whose first word is zero (so also the first draw after
// reset) reseeds with 4357 first. Reset clears the index and the current-word
// register; the table itself needs no clearing.
// While a finished word waits under out_stall, one more item is taken and its
// result is held in the twist stage until the output register frees.

module mersenne_twister_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [31:0] seed_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] random_word
);

	mtg_pkg::mtg_cmd_t cmd;
	mtg_pkg::mtg_sts_t sts;

	mtg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.opcode   (opcode),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	mtg_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed_value  (seed_value),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_word (random_word)
	);

endmodule

@@ tb/sv/mersenne_twister_generator_checker.sv @@
`timescale 1ns / 1ps

module mersenne_twister_generator_checker
	import mtg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic        opcode,
	input  logic [31:0] seed_value,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [31:0] random_word,
	output int          mismatches,
	output int          pending
);

	localparam logic [31:0] TOP_BIT   = 32'h80000000;
	localparam logic [31:0] LOW_BITS  = 32'h7FFFFFFF;
	localparam int          MAX_SHOWN = 10;

	// shadow of the generator state
	logic [31:0]      mt_table [0:TABLE_WORDS-1];
	logic [IDX_W-1:0] read_pos;
	logic [31:0]      expected_words [$];

	// fill the table from a seed, two LCG steps per word
	function automatic void seed_table(input logic [31:0] seed);
		logic [31:0] lcg;
		logic [31:0] hi;
		lcg = seed;
		for (int i = 0; i < TABLE_WORDS; i++) begin
			hi = lcg & HIGH_HALF;
			lcg = 32'd1 + LCG_MUL * lcg;
			mt_table[i] = hi | (lcg >> 16);
			lcg = 32'd1 + LCG_MUL * lcg;
		end
		read_pos = '0;
	endfunction

	// regenerate the whole table in place
	function automatic void twist_table();
		logic [31:0] y;
		logic [31:0] mix;
		int          nxt;
		int          far_pos;
		for (int i = 0; i < TABLE_WORDS; i++) begin
			nxt = (i + 1) % TABLE_WORDS;
			far_pos = (i + TWIST_OFFSET) % TABLE_WORDS;
			y = (mt_table[i] & TOP_BIT) | (mt_table[nxt] & LOW_BITS);
			mix = (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
			mt_table[i] = mt_table[far_pos] ^ mix;
		end
	endfunction

	function automatic logic [31:0] tempered(input logic [31:0] raw);
		logic [31:0] t;
		t = raw ^ (raw >> 11);
		t = t ^ ((t << 7) & TEMPER_B);
		t = t ^ ((t << 15) & TEMPER_C);
		t = t ^ (t >> 18);
		return t;
	endfunction

	// work out the word a draw returns and advance the index
	function automatic logic [31:0] next_draw();
		logic [31:0] w;
		if (read_pos == '0) begin
			if (mt_table[0] == 32'd0)
				seed_table(DEFAULT_SEED);
			twist_table();
		end
		w = tempered(mt_table[read_pos]);
		read_pos = (read_pos == LAST_IDX) ? '0 : read_pos + 1'b1;
		return w;
	endfunction

	// compare finished words first, then take the new request
	always @(posedge clk or negedge arst_n) begin
		logic [31:0] want;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_WORDS; i++)
				mt_table[i] = '0;
			read_pos = '0;
			expected_words.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_words.size() == 0) begin
					if (mismatches < MAX_SHOWN)
						$display("%0t: unexpected random_word %h", $realtime, random_word);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (random_word !== want) begin
						if (mismatches < MAX_SHOWN)
							$display("%0t: random_word expected %h got %h",
								$realtime, want, random_word);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (opcode == OP_SEED)
					seed_table(seed_value);
				else
					expected_words.push_back(next_draw());
			end
			pending <= expected_words.size();
		end
	end

endmodule

@@ tb/sv/mersenne_twister_generator_tb.sv @@
`timescale 1ns / 1ps

module mersenne_twister_generator_tb;
	import mtg_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 40;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic [31:0] seed_value;
	logic        out_valid;
	logic        out_stall;
	logic [31:0] random_word;

	int mismatches;
	int pending;
	int cycles = 0;
	int tx_max;
	int rx_max;
	int stall_left;

	mersenne_twister_generator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.seed_value  (seed_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_word (random_word)
	);

	mersenne_twister_generator_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.seed_value  (seed_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_word (random_word),
		.mismatches  (mismatches),
		.pending     (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// hold off each finished word for a random number of cycles
	always @(posedge clk or negedge arst_n) begin
		int hold;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (out_valid && !out_stall) begin
			hold = $urandom_range(0, rx_max);
			out_stall <= (hold != 0);
			stall_left <= hold;
		end else if (stall_left > 0) begin
			out_stall <= (stall_left > 1);
			stall_left <= stall_left - 1;
		end
	end

	// offer one request word after a random gap and wait for it to be taken
	task automatic send_word(input logic op, input logic [31:0] value);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		seed_value <= value;
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending until every expected word has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		logic        op;
		logic [31:0] value;
		arst_n = 1'b0;
		in_valid = 1'b0;
		opcode = OP_DRAW;
		seed_value = 32'd0;
		tx_max = 13;
		rx_max = 13;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// draws straight after reset hit the empty table
		send_word(OP_DRAW, 32'h00000000);
		send_word(OP_DRAW, 32'hFFFFFFFF);
		// a zero seed leaves word 0 empty, so the next draw reseeds by default
		send_word(OP_SEED, 32'h00000000);
		send_word(OP_DRAW, 32'hAAAAAAAA);
		send_word(OP_DRAW, 32'h55555555);
		send_word(OP_SEED, 32'hFFFFFFFF);
		send_word(OP_DRAW, 32'h00000000);
		send_word(OP_DRAW, 32'hFFFFFFFF);
		send_word(OP_SEED, 32'h00000001);
		send_word(OP_DRAW, 32'h12345678);
		send_word(OP_SEED, 32'h80000000);
		send_word(OP_DRAW, 32'h80000000);
		// back-to-back seeds: only the last one counts
		send_word(OP_SEED, 32'h7FFFFFFF);
		send_word(OP_SEED, DEFAULT_SEED);
		send_word(OP_DRAW, 32'h7FFFFFFF);
		send_word(OP_DRAW, 32'h00000001);
		send_word(OP_SEED, 32'h5A5A5A5A);
		send_word(OP_DRAW, 32'hA5A5A5A5);
		send_word(OP_DRAW, 32'hDEADBEEF);
		drain();

		// long run of draws, past the end of the table and through a twist
		for (int k = 0; k < 630; k++) begin
			case (k)
				0:   begin tx_max = 0;  rx_max = 0;  end
				150: begin tx_max = 13; rx_max = 13; end
				400: begin tx_max = 13; rx_max = 0;  end
				520: begin tx_max = 0;  rx_max = 13; end
				default: ;
			endcase
			send_word(OP_DRAW, $urandom());
		end

		// mixed draws and occasional reseeds
		tx_max = 13;
		rx_max = 13;
		for (int k = 0; k < 130; k++) begin
			if (k == 70) begin
				tx_max = 0;
				rx_max = 0;
			end
			op = ($urandom_range(0, 7) == 0) ? OP_SEED : OP_DRAW;
			value = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom();
			send_word(op, value);
		end

		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

@@ files.f @@
sv/mtg_pkg.sv
sv/mtg_ctrl.sv
sv/mtg_dp.sv
sv/mersenne_twister_generator.sv
tb/sv/mersenne_twister_generator_checker.sv
tb/sv/mersenne_twister_generator_tb.sv
